[design/ffa_pkg.sv]
// Shared types, codes and helpers for the first-fit free-list allocator.
// No dependencies.
`default_nettype none

package ffa_pkg;

	localparam int unsigned FREE_SLOTS_DEF = 4096;
	localparam int unsigned ADDR_BITS_DEF  = 32;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_LOST  = 2'd2;

	typedef struct packed {
		logic        op;
		logic [31:0] block_addr;
		logic [31:0] block_size;
	} in_t;

	typedef struct packed {
		logic [31:0] granted_addr;
		logic [1:0]  status;
		logic [31:0] free_total;
		logic [12:0] region_count;
		logic [12:0] peak_region_count;
		logic [31:0] lost_count;
		logic [31:0] lost_bytes;
	} out_t;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

`default_nettype wire

[design/first_fit_free_list_allocator_unit.sv]
// Each beat runs an address scan over the used regions, then shifts table entries
// when a region is removed or inserted.
// One beat in flight; the next beat is taken while a finished result waits.
// The scan and the entry shifts run over the table's one read port and one write port.
// Reset clears counters and totals; table contents stay undefined until written.
// Depends on ffa_pkg and ffa_ram.
`default_nettype none

module first_fit_free_list_allocator_unit
	import ffa_pkg::*;
#(
	parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF,
	parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	localparam int unsigned IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(FREE_SLOTS + 1);
	localparam int unsigned SUM_W = 32 + IDX_W + 1;
	localparam int unsigned EW    = ADDR_BITS + 32;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHDN   = 3'd3;
	localparam logic [2:0] S_SHUP   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]           state_q;
	logic                 op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [31:0]          size_q;
	logic [CNT_W-1:0]     used_q, peak_q, rd_idx_q, hit_q, ridx_s1;
	logic                 rv_s1, sh_go_q, have_prev_q, have_cur_q;
	logic [EW-1:0]        prev_q, cur_q;
	logic [31:0]          lost_cnt_q, lost_bytes_q, granted_q;
	logic [1:0]           status_q;
	logic [SUM_W-1:0]     total_q;

	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [EW-1:0]        mem_wdata, mem_rdata;

	ffa_ram #(.DEPTH(FREE_SLOTS), .WIDTH(EW), .AW(IDX_W)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Entry fields
	logic [ADDR_BITS-1:0] prev_start, cur_start, rd_start;
	logic [31:0]          prev_len, cur_len, rd_len;
	assign prev_start = prev_q[EW-1:32];
	assign prev_len   = prev_q[31:0];
	assign cur_start  = cur_q[EW-1:32];
	assign cur_len    = cur_q[31:0];
	assign rd_start   = mem_rdata[EW-1:32];
	assign rd_len     = mem_rdata[31:0];

	logic [ADDR_BITS+31:0] in_addr_x, p_sum, f_sum, a_sum;
	logic [ADDR_BITS-1:0]  in_addr, p_end, f_end, a_new;
	logic [ADDR_BITS+31:0] g_x;
	assign in_addr_x = {ADDR_BITS'(0), in_data.block_addr};
	assign in_addr   = in_addr_x[ADDR_BITS-1:0];
	assign p_sum     = {32'(0), prev_start} + {ADDR_BITS'(0), prev_len};
	assign f_sum     = {32'(0), addr_q} + {ADDR_BITS'(0), size_q};
	assign a_sum     = {32'(0), cur_start} + {ADDR_BITS'(0), size_q};
	assign p_end     = p_sum[ADDR_BITS-1:0];
	assign f_end     = f_sum[ADDR_BITS-1:0];
	assign a_new     = a_sum[ADDR_BITS-1:0];
	assign g_x       = {32'(0), cur_start};

	logic [31:0] l1, l2, lh;
	assign l1 = sat32(prev_len, size_q);
	assign l2 = sat32(l1, cur_len);
	assign lh = sat32(cur_len, size_q);

	logic merge_lo, merge_hi, can_ins, a_fail, a_rm;
	assign merge_lo = have_prev_q && (p_end == addr_q);
	assign merge_hi = have_cur_q && (f_end == cur_start);
	assign can_ins  = used_q < CNT_W'(FREE_SLOTS);
	assign a_fail   = !have_cur_q;
	assign a_rm     = have_cur_q && (cur_len == size_q);

	logic [CNT_W-1:0] hit_m1, hit_p1, ridx_m1, ridx_p1, used_m1;
	assign hit_m1  = hit_q - 1'b1;
	assign hit_p1  = hit_q + 1'b1;
	assign ridx_m1 = ridx_s1 - 1'b1;
	assign ridx_p1 = ridx_s1 + 1'b1;
	assign used_m1 = used_q - 1'b1;

	// Scan hit test on returning read data
	logic scan_hit, scan_last, scan_leave;
	assign scan_hit   = rv_s1 && ((op_q == OP_ALLOC) ? (rd_len >= size_q) : (rd_start > addr_q));
	assign scan_last  = rv_s1 && (ridx_s1 == used_m1);
	assign scan_leave = scan_hit || scan_last;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = hit_q[IDX_W-1:0];
		mem_wdata = {addr_q, size_q};
		unique case (state_q)
			S_SCAN: begin
				mem_re = (rd_idx_q < used_q) && !scan_leave;
			end
			S_DECIDE: begin
				if (op_q == OP_ALLOC) begin
					mem_we    = have_cur_q && !a_rm;
					mem_wdata = {a_new, cur_len - size_q};
				end else if (merge_lo) begin
					mem_we    = 1'b1;
					mem_waddr = hit_m1[IDX_W-1:0];
					mem_wdata = {prev_start, merge_hi ? l2 : l1};
				end else if (merge_hi) begin
					mem_we    = 1'b1;
					mem_wdata = {addr_q, lh};
				end else begin
					mem_we = can_ins && (hit_q == used_q);
				end
			end
			S_SHDN: begin
				mem_re    = sh_go_q;
				mem_we    = rv_s1;
				mem_waddr = ridx_m1[IDX_W-1:0];
				mem_wdata = mem_rdata;
			end
			S_SHUP: begin
				mem_re = sh_go_q;
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_p1[IDX_W-1:0];
					mem_wdata = mem_rdata;
				end else if (!sh_go_q) begin
					mem_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	logic [SUM_W-1:0] tot_x_size, tot_x_plen, tot_x_clen, tot_x_l1, tot_x_l2, tot_x_lh;
	assign tot_x_size = SUM_W'(size_q);
	assign tot_x_plen = SUM_W'(prev_len);
	assign tot_x_clen = SUM_W'(cur_len);
	assign tot_x_l1   = SUM_W'(l1);
	assign tot_x_l2   = SUM_W'(l2);
	assign tot_x_lh   = SUM_W'(lh);

	logic [CNT_W+12:0] used_x, peak_x;
	assign used_x = {13'd0, used_q};
	assign peak_x = {13'd0, peak_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			peak_q       <= '0;
			lost_cnt_q   <= '0;
			lost_bytes_q <= '0;
			total_q      <= '0;
			rv_s1        <= 1'b0;
			sh_go_q      <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= in_data.op;
						addr_q      <= in_addr;
						size_q      <= in_data.block_size;
						rd_idx_q    <= '0;
						have_prev_q <= 1'b0;
						have_cur_q  <= 1'b0;
						hit_q       <= '0;
						rv_s1       <= 1'b0;
						state_q     <= (used_q == '0) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					rv_s1   <= mem_re;
					ridx_s1 <= rd_idx_q;
					if (mem_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rv_s1 && !scan_hit && op_q == OP_FREE) begin
						prev_q      <= mem_rdata;
						have_prev_q <= 1'b1;
					end
					if (scan_hit) begin
						cur_q      <= mem_rdata;
						have_cur_q <= 1'b1;
						hit_q      <= ridx_s1;
					end else if (scan_last) begin
						hit_q <= used_q;
					end
					if (scan_leave) begin
						rv_s1   <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					granted_q <= '0;
					status_q  <= ST_OK;
					state_q   <= S_DONE;
					if (op_q == OP_ALLOC) begin
						if (a_fail) begin
							status_q <= ST_NOFIT;
						end else begin
							granted_q <= g_x[31:0];
							total_q   <= total_q - tot_x_size;
							if (a_rm) begin
								used_q   <= used_m1;
								rd_idx_q <= hit_p1;
								sh_go_q  <= hit_p1 < used_q;
								state_q  <= S_SHDN;
							end
						end
					end else if (merge_lo) begin
						if (merge_hi) begin
							total_q  <= total_q + tot_x_l2 - tot_x_plen - tot_x_clen;
							used_q   <= used_m1;
							rd_idx_q <= hit_p1;
							sh_go_q  <= hit_p1 < used_q;
							state_q  <= S_SHDN;
						end else begin
							total_q <= total_q + tot_x_l1 - tot_x_plen;
						end
					end else if (merge_hi) begin
						total_q <= total_q + tot_x_lh - tot_x_clen;
					end else if (can_ins) begin
						total_q <= total_q + tot_x_size;
						used_q  <= used_q + 1'b1;
						if (peak_q < used_q + 1'b1) begin
							peak_q <= used_q + 1'b1;
						end
						if (hit_q != used_q) begin
							rd_idx_q <= used_m1;
							sh_go_q  <= 1'b1;
							state_q  <= S_SHUP;
						end
					end else begin
						status_q     <= ST_LOST;
						lost_cnt_q   <= lost_cnt_q + 1'b1;
						lost_bytes_q <= sat32(lost_bytes_q, size_q);
					end
				end
				S_SHDN: begin
					rv_s1   <= sh_go_q;
					ridx_s1 <= rd_idx_q;
					if (sh_go_q) begin
						if (rd_idx_q == used_q) begin
							sh_go_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (!sh_go_q && !rv_s1) begin
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					rv_s1   <= sh_go_q;
					ridx_s1 <= rd_idx_q;
					if (sh_go_q) begin
						if (rd_idx_q == hit_q) begin
							sh_go_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
						end
					end
					if (!sh_go_q && !rv_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid                  <= 1'b1;
						out_data.granted_addr      <= granted_q;
						out_data.status            <= status_q;
						out_data.free_total        <= (|total_q[SUM_W-1:32]) ?
							32'hFFFF_FFFF : total_q[31:0];
						out_data.region_count      <= used_x[12:0];
						out_data.peak_region_count <= peak_x[12:0];
						out_data.lost_count        <= lost_cnt_q;
						out_data.lost_bytes        <= lost_bytes_q;
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(FREE_SLOTS))
		else $error("region count above table depth");

	a_peak_ge: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q)
		else $error("peak below current region count");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_we)
		else $error("table written during scan");

	a_lost_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == ST_LOST) |-> (used_q == CNT_W'(FREE_SLOTS)))
		else $error("beat dropped with free slots left");

endmodule

`default_nettype wire

[design/ffa_ram.sv]
// Simple dual-port region table memory, registered read.
// No dependencies.
`default_nettype none

module ffa_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 64,
	parameter int unsigned AW    = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
